// ===== src/flc_pkg.sv =====
// Shared constants, types and helper functions of the full linear convolver.
`default_nettype none

package flc_pkg;

    localparam int MAX_TAPS    = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int VALUE_W     = 16;
    localparam int RESULT_W    = 36;
    localparam int PROD_W      = 2 * SAMPLE_BITS;
    localparam int IDX_W       = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int TCNT_W      = $clog2(MAX_TAPS + 1);

    // item opcodes
    localparam logic OP_KERNEL = 1'b0;
    localparam logic OP_DATA   = 1'b1;

    typedef logic        [VALUE_W-1:0]     t_value;
    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [PROD_W-1:0]      t_prod;
    typedef logic signed [RESULT_W-1:0]    t_result;
    typedef logic        [IDX_W-1:0]       t_tap_idx;
    typedef logic        [TCNT_W-1:0]      t_tap_cnt;

    typedef struct packed {
        logic tick;      // advance the chain by one sample
        logic clr_hist;  // zero the sample history instead of shifting
    } t_cell_ctl;

    // Sign-extend from the low SAMPLE_BITS bits of the raw field.
    function automatic t_sample to_sample(input t_value v);
        logic [SAMPLE_BITS+VALUE_W-1:0] w;
        w = {{SAMPLE_BITS{1'b0}}, v};
        return t_sample'(w[SAMPLE_BITS-1:0]);
    endfunction

    // Fit a product to the result width: sign-extend or wrap.
    function automatic t_result fit_result(input t_prod p);
        logic [PROD_W+RESULT_W-1:0] w;
        w = {{RESULT_W{p[PROD_W-1]}}, p};
        return t_result'(w[RESULT_W-1:0]);
    endfunction

endpackage

`default_nettype wire

// ===== src/flc_if.sv =====
// Valid/ready channel interfaces for input items and result items.
`default_nettype none

interface flc_in_if;
    import flc_pkg::*;

    logic   valid;
    logic   ready;
    logic   op;
    t_value value;
    logic   last_in;

    modport source (output valid, op, value, last_in, input ready);
    modport sink   (input valid, op, value, last_in, output ready);
endinterface

interface flc_out_if;
    import flc_pkg::*;

    logic    valid;
    logic    ready;
    t_result result;
    logic    last_out;

    modport source (output valid, result, last_out, input ready);
    modport sink   (input valid, result, last_out, output ready);
endinterface

`default_nettype wire

// ===== src/flc_cell.sv =====
// One transposed-form cell: tap, one history sample and one partial sum.
`default_nettype none

module flc_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  flc_pkg::t_cell_ctl i_ctl,
    input  logic               i_en,
    input  logic               i_tap_we,
    input  flc_pkg::t_sample   i_tap,
    input  flc_pkg::t_sample   i_x,
    input  flc_pkg::t_sample   i_hist,
    input  flc_pkg::t_result   i_sum,
    output flc_pkg::t_sample   o_hist,
    output flc_pkg::t_result   o_sum
);
    import flc_pkg::*;

    t_sample r_tap;
    t_sample r_hist;
    t_result r_sum;
    t_prod   w_prod;
    t_result n_sum;

    assign w_prod = t_prod'(r_tap) * t_prod'(i_x);
    // cells past the tap count contribute nothing
    assign n_sum  = (i_en ? fit_result(w_prod) : t_result'(0)) + i_sum;

    always_ff @(posedge i_clk) begin
        if (i_tap_we) begin
            r_tap <= i_tap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
            r_sum  <= '0;
        end else if (i_ctl.tick) begin
            r_sum  <= n_sum;
            r_hist <= i_ctl.clr_hist ? t_sample'(0) : i_hist;
        end
    end

    assign o_hist = r_hist;
    assign o_sum  = r_sum;

endmodule

`default_nettype wire

// ===== src/full_linear_convolver.sv =====
// Full linear convolver top level: input buffer, sequencer and the cell chain.
// A sample item is registered in the input buffer, and its result in the cell partial sums.
// Throughput: one sample or kernel item per cycle while the output is not stalled and no
// flush runs; the first sample after any kernel item waits while the history replays.
// A final sample is followed by M-1 tail results, one per cycle unless the output stalls.
// Reset (synchronous): history, partial sums, tap count and control clear; taps undefined.
`default_nettype none

module full_linear_convolver (
    input  logic             i_clk,
    input  logic             i_rst_n,
    flc_in_if.sink           i_in_ch,
    flc_out_if.source        o_out_ch
);
    import flc_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_REPLAY = 2'd1;
    localparam logic [1:0] ST_FLUSH  = 2'd2;

    logic      [1:0] r_state,     n_state;
    t_tap_cnt        r_cnt,       n_cnt;
    logic            r_dirty,     n_dirty;
    t_tap_idx        r_tap_idx,   n_tap_idx;
    logic            r_taps_full, n_taps_full;
    t_tap_cnt        r_tap_count, n_tap_count;
    logic            r_out_valid, n_out_valid;
    logic            r_out_last,  n_out_last;

    logic            r_in_valid;
    logic            r_in_op;
    t_sample         r_in_x;
    logic            r_in_last;

    t_cell_ctl       w_ctl;
    logic            w_replay;
    logic            w_flush;
    logic            w_tap_we;
    logic            w_done;
    logic            w_slot;
    logic            w_in_acc;
    logic            w_flush_end;
    t_sample         w_x;

    t_sample         w_hist_chain [0:MAX_TAPS];
    t_result         w_sum_chain  [0:MAX_TAPS];

    assign w_slot      = !r_out_valid || o_out_ch.ready;
    assign i_in_ch.ready = !r_in_valid || w_done;
    assign w_in_acc    = i_in_ch.valid && i_in_ch.ready;
    assign w_flush_end = ({1'b0, r_cnt} + (TCNT_W+1)'(2)) == {1'b0, r_tap_count};

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_dirty     = r_dirty;
        n_tap_idx   = r_tap_idx;
        n_taps_full = r_taps_full;
        n_tap_count = r_tap_count;
        n_out_valid = r_out_valid && !o_out_ch.ready;
        n_out_last  = r_out_last;
        w_ctl       = '0;
        w_replay    = 1'b0;
        w_flush     = 1'b0;
        w_tap_we    = 1'b0;
        w_done      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (r_in_valid) begin
                    if (r_in_op == OP_KERNEL) begin
                        w_done  = 1'b1;
                        n_dirty = 1'b1;
                        // drop taps past the last slot
                        if (!r_taps_full) begin
                            w_tap_we = 1'b1;
                            if (r_tap_idx == IDX_W'(MAX_TAPS - 1)) begin
                                n_taps_full = 1'b1;
                            end else begin
                                n_tap_idx = r_tap_idx + IDX_W'(1);
                            end
                        end
                        if (r_in_last) begin
                            n_tap_count = n_taps_full ? TCNT_W'(MAX_TAPS)
                                                      : TCNT_W'(n_tap_idx);
                            n_tap_idx   = '0;
                            n_taps_full = 1'b0;
                        end
                    end else if (r_dirty) begin
                        n_state = ST_REPLAY;
                        n_cnt   = '0;
                    end else if (w_slot) begin
                        w_ctl.tick  = 1'b1;
                        n_out_valid = 1'b1;
                        if (r_in_last && (r_tap_count > TCNT_W'(1))) begin
                            n_state    = ST_FLUSH;
                            n_cnt      = '0;
                            n_out_last = 1'b0;
                        end else begin
                            n_out_last     = r_in_last;
                            w_ctl.clr_hist = r_in_last;
                            w_done         = 1'b1;
                        end
                    end
                end
            end
            ST_REPLAY: begin
                // rebuild the partial sums from the history with the current taps
                if (w_slot) begin
                    w_ctl.tick = 1'b1;
                    w_replay   = 1'b1;
                    if (r_cnt == TCNT_W'(MAX_TAPS - 1)) begin
                        n_state = ST_IDLE;
                        n_dirty = 1'b0;
                    end else begin
                        n_cnt = r_cnt + TCNT_W'(1);
                    end
                end
            end
            ST_FLUSH: begin
                if (w_slot) begin
                    w_ctl.tick  = 1'b1;
                    w_flush     = 1'b1;
                    n_out_valid = 1'b1;
                    if (w_flush_end) begin
                        n_out_last     = 1'b1;
                        w_ctl.clr_hist = 1'b1;
                        w_done         = 1'b1;
                        n_state        = ST_IDLE;
                    end else begin
                        n_out_last = 1'b0;
                        n_cnt      = r_cnt + TCNT_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_dirty     <= 1'b0;
            r_tap_idx   <= '0;
            r_taps_full <= 1'b0;
            r_tap_count <= '0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
            r_in_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_dirty     <= n_dirty;
            r_tap_idx   <= n_tap_idx;
            r_taps_full <= n_taps_full;
            r_tap_count <= n_tap_count;
            r_out_valid <= n_out_valid;
            r_out_last  <= n_out_last;
            if (w_in_acc) begin
                r_in_valid <= 1'b1;
            end else if (w_done) begin
                r_in_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_op   <= i_in_ch.op;
            r_in_x    <= to_sample(i_in_ch.value);
            r_in_last <= i_in_ch.last_in;
        end
    end

    // replay rotates the oldest held sample back into the head
    assign w_x = w_replay ? w_hist_chain[MAX_TAPS] :
                 w_flush  ? t_sample'(0)           : r_in_x;

    assign w_hist_chain[0]        = w_x;
    assign w_sum_chain[MAX_TAPS]  = '0;

    for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
        flc_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_en     (TCNT_W'(j) < r_tap_count),
            .i_tap_we (w_tap_we && (r_tap_idx == IDX_W'(j))),
            .i_tap    (r_in_x),
            .i_x      (w_x),
            .i_hist   (w_hist_chain[j]),
            .i_sum    (w_sum_chain[j+1]),
            .o_hist   (w_hist_chain[j+1]),
            .o_sum    (w_sum_chain[j])
        );
    end

    assign o_out_ch.valid    = r_out_valid;
    assign o_out_ch.result   = w_sum_chain[0];
    assign o_out_ch.last_out = r_out_last;

endmodule

`default_nettype wire

// ===== src/flc_chk.sv =====
// Port-level assertions for the full linear convolver and their bind.
`default_nettype none

module flc_chk (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_in_op,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input flc_pkg::t_result i_out_result,
    input logic             i_out_last
);
    import flc_pkg::*;

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_result) && $stable(i_out_last))
        else $error("result item changed while stalled");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result item valid right after reset");

    // a kernel item never launches a result on its own
    a_kernel_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_op == OP_KERNEL) |-> ##2 !$rose(i_out_valid))
        else $error("kernel item produced a result");

endmodule

bind full_linear_convolver flc_chk u_flc_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_ch.valid),
    .i_in_ready   (i_in_ch.ready),
    .i_in_op      (i_in_ch.op),
    .i_out_valid  (o_out_ch.valid),
    .i_out_ready  (o_out_ch.ready),
    .i_out_result (o_out_ch.result),
    .i_out_last   (o_out_ch.last_out)
);

`default_nettype wire

// ===== tb/full_linear_convolver_tb.sv =====
// Testbench of the full linear convolver: directed table and random sequences against a predictor.
`timescale 1ns / 100ps

module full_linear_convolver_tb;
    import flc_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_ITEMS = 70;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int NUM_DIR      = 19;

    typedef struct packed {
        logic    op;
        t_value  value;
        logic    last;
        logic    typed;     // expected result written in the row
        t_result res;
        logic    res_last;
    } t_stim_row;

    typedef struct packed {
        t_result result;
        logic    last;
    } t_conv_out;

    typedef enum int {
        RDY_ALWAYS,
        RDY_HALF,
        RDY_PERIODIC,
        RDY_MOSTLY,
        RDY_SPARSE
    } t_ready_mode;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    flc_in_if  in_ch ();
    flc_out_if out_ch ();

    full_linear_convolver dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // typed expectation travels alongside the item on the channel
    logic    row_typed    = 1'b0;
    t_result row_res      = '0;
    logic    row_res_last = 1'b0;

    bit hold_req = 1'b0;
    bit no_gaps  = 1'b0;
    int burst_left = 0;
    int fail_cnt   = 0;
    int cycle_cnt  = 0;

    t_conv_out expected_outs[$];

    // predictor state
    shortint coef [MAX_TAPS];
    shortint hist [MAX_TAPS-1];
    int      ntaps     = 0;
    int      wr_idx    = 0;
    bit      load_full = 1'b0;

    t_stim_row dir_tab [NUM_DIR] = '{
        '{OP_DATA,   16'h7fff, 1'b0, 1'b1, 36'sd0, 1'b0},  // no kernel yet
        '{OP_DATA,   16'h8000, 1'b1, 1'b1, 36'sd0, 1'b1},  // no kernel, last: no tail
        '{OP_KERNEL, 16'h0001, 1'b1, 1'b0, 36'sd0, 1'b0},
        '{OP_DATA,   16'h0005, 1'b1, 1'b1, 36'sd5, 1'b1},
        '{OP_KERNEL, 16'h8000, 1'b1, 1'b0, 36'sd0, 1'b0},
        '{OP_DATA,   16'h8000, 1'b1, 1'b1, 36'sd1073741824, 1'b1},
        '{OP_KERNEL, 16'h8000, 1'b0, 1'b0, 36'sd0, 1'b0},
        '{OP_KERNEL, 16'h8000, 1'b1, 1'b0, 36'sd0, 1'b0},
        '{OP_DATA,   16'h8000, 1'b0, 1'b0, 36'sd0, 1'b0},
        '{OP_DATA,   16'h8000, 1'b1, 1'b0, 36'sd0, 1'b0},
        '{OP_KERNEL, 16'h7fff, 1'b0, 1'b0, 36'sd0, 1'b0},
        '{OP_KERNEL, 16'h8000, 1'b0, 1'b0, 36'sd0, 1'b0},
        '{OP_KERNEL, 16'h0003, 1'b1, 1'b0, 36'sd0, 1'b0},
        '{OP_DATA,   16'h8000, 1'b0, 1'b0, 36'sd0, 1'b0},
        '{OP_DATA,   16'h7fff, 1'b0, 1'b0, 36'sd0, 1'b0},
        '{OP_KERNEL, 16'h0007, 1'b1, 1'b0, 36'sd0, 1'b0},  // reload mid-sequence
        '{OP_DATA,   16'hffff, 1'b0, 1'b0, 36'sd0, 1'b0},
        '{OP_KERNEL, 16'h1234, 1'b0, 1'b0, 36'sd0, 1'b0},  // open load overwrites tap 0
        '{OP_DATA,   16'h0001, 1'b1, 1'b0, 36'sd0, 1'b0}
    };

    // One output for sample x, then shift x into the history.
    function automatic longint tick_chain(input shortint x);
        longint acc;
        acc = 0;
        if (ntaps > 0)
            acc = longint'(coef[0]) * longint'(x);
        for (int j = 1; j < ntaps; j++)
            acc += longint'(coef[j]) * longint'(hist[j-1]);
        for (int k = MAX_TAPS - 2; k >= 1; k--)
            hist[k] = hist[k-1];
        hist[0] = x;
        return acc;
    endfunction

    task automatic convolve_item(input logic op, input t_value value, input logic last);
        shortint   x;
        int        tail;
        t_conv_out o;
        x = shortint'($signed(value[SAMPLE_BITS-1:0]));
        if (op == OP_KERNEL) begin
            // drop taps past the store size
            if (!load_full) begin
                coef[wr_idx] = x;
                if (wr_idx + 1 >= MAX_TAPS)
                    load_full = 1'b1;
                else
                    wr_idx++;
            end
            if (last) begin
                ntaps     = load_full ? MAX_TAPS : wr_idx;
                wr_idx    = 0;
                load_full = 1'b0;
            end
        end else begin
            tail     = (last && ntaps > 0) ? ntaps - 1 : 0;
            o.result = t_result'(tick_chain(x));
            o.last   = last && (tail == 0);
            expected_outs.push_back(o);
            for (int t = 0; t < tail; t++) begin
                o.result = t_result'(tick_chain(16'sd0));
                o.last   = (t + 1 == tail);
                expected_outs.push_back(o);
            end
            if (last) begin
                for (int k = 0; k < MAX_TAPS - 1; k++)
                    hist[k] = 16'sd0;
            end
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_conv_out exp_out;
        int        n0;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                n0 = expected_outs.size();
                convolve_item(in_ch.op, in_ch.value, in_ch.last_in);
                if (row_typed) begin
                    while (expected_outs.size() > n0)
                        void'(expected_outs.pop_back());
                    exp_out.result = row_res;
                    exp_out.last   = row_res_last;
                    expected_outs.push_back(exp_out);
                end
            end
            if (out_ch.valid && out_ch.ready) begin
                if (expected_outs.size() == 0) begin
                    $error("unexpected result item: result %0d, last_out %0b",
                           out_ch.result, out_ch.last_out);
                    fail_cnt++;
                end else begin
                    exp_out = expected_outs.pop_front();
                    if (out_ch.result !== exp_out.result) begin
                        $error("result: expected %0d, actual %0d", exp_out.result, out_ch.result);
                        fail_cnt++;
                    end
                    if (out_ch.last_out !== exp_out.last) begin
                        $error("last_out: expected %0b, actual %0b", exp_out.last, out_ch.last_out);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver: segments of different ready patterns, one long hold on request.
    initial begin : receiver
        t_ready_mode mode;
        int          seg_left;
        bit          hold_done;
        mode      = RDY_ALWAYS;
        seg_left  = 0;
        hold_done = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                if (seg_left == 0) begin
                    mode     = t_ready_mode'($urandom_range(0, 4));
                    seg_left = $urandom_range(10, 60);
                end
                seg_left--;
                case (mode)
                    RDY_ALWAYS:   out_ch.ready <= 1'b1;
                    RDY_HALF:     out_ch.ready <= 1'($urandom_range(0, 1));
                    RDY_PERIODIC: out_ch.ready <= (seg_left % 6) < 3;
                    RDY_MOSTLY:   out_ch.ready <= ($urandom_range(0, 7) != 0);
                    default:      out_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    function automatic t_value pick_value();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return t_value'($urandom);
        endcase
    endfunction

    // Offer one item from a falling edge, hold until accepted, then maybe idle.
    task automatic send_item(input logic op, input t_value value, input logic last,
                             input logic typed, input t_result res, input logic res_last);
        int gap;
        in_ch.valid   <= 1'b1;
        in_ch.op      <= op;
        in_ch.value   <= value;
        in_ch.last_in <= last;
        row_typed     <= typed;
        row_res       <= res;
        row_res_last  <= res_last;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        if (!no_gaps) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                gap = $urandom_range(1, 6);
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                          : $urandom_range(0, 10);
            end
        end
    endtask

    task automatic send_kernel(input int len);
        for (int i = 0; i < len; i++)
            send_item(OP_KERNEL, pick_value(), i == len - 1, 1'b0, '0, 1'b0);
    endtask

    task automatic send_sequence(input int len);
        for (int i = 0; i < len; i++)
            send_item(OP_DATA, pick_value(), i == len - 1, 1'b0, '0, 1'b0);
    endtask

    initial begin : stimulus
        int rnd_items;
        int len;
        int r;
        in_ch.valid   = 1'b0;
        in_ch.op      = OP_KERNEL;
        in_ch.value   = '0;
        in_ch.last_in = 1'b0;
        for (int k = 0; k < MAX_TAPS; k++)
            coef[k] = 16'sd0;
        for (int k = 0; k < MAX_TAPS - 1; k++)
            hist[k] = 16'sd0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < NUM_DIR; i++)
            send_item(dir_tab[i].op, dir_tab[i].value, dir_tab[i].last,
                      dir_tab[i].typed, dir_tab[i].res, dir_tab[i].res_last);

        // keep offering items while the receiver holds off
        hold_req = 1'b1;
        no_gaps  = 1'b1;
        send_kernel(MAX_TAPS);
        send_sequence(24);
        no_gaps  = 1'b0;

        rnd_items = 0;
        while (rnd_items < RANDOM_ITEMS) begin
            r = $urandom_range(0, 19);
            if (r < 5) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(MAX_TAPS + 1, MAX_TAPS + 4)
                                                  : $urandom_range(1, MAX_TAPS);
                send_kernel(len);
            end else if (r < 17) begin
                len = $urandom_range(1, 12);
                send_sequence(len);
            end else begin
                len = 1;
                send_item(1'($urandom_range(0, 1)), pick_value(), 1'($urandom_range(0, 1)),
                          1'b0, '0, 1'b0);
            end
            rnd_items += len;
        end
        in_ch.valid <= 1'b0;

        while (expected_outs.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0 && expected_outs.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/flc_pkg.sv
src/flc_if.sv
src/flc_cell.sv
src/full_linear_convolver.sv
src/flc_chk.sv
tb/full_linear_convolver_tb.sv
